/* rtl/i2cm_pkg.sv */
package i2cm_pkg;

	// command codes carried in the func field
	localparam logic [2:0] FN_NONE  = 3'd0;
	localparam logic [2:0] FN_START = 3'd1;
	localparam logic [2:0] FN_STOP  = 3'd2;
	localparam logic [2:0] FN_WRITE = 3'd3;
	localparam logic [2:0] FN_WACK  = 3'd4;
	localparam logic [2:0] FN_READ  = 3'd5;
	localparam logic [2:0] FN_ACK   = 3'd6;
	localparam logic [2:0] FN_NACK  = 3'd7;

	// register indexes on the configuration port
	localparam logic [1:0] REG_SHORT   = 2'd0;
	localparam logic [1:0] REG_LONG    = 2'd1;
	localparam logic [1:0] REG_TIMEOUT = 2'd2;

	// register reset values
	localparam logic [15:0] SHORT_RST   = 16'd100;
	localparam logic [15:0] LONG_RST    = 16'd200;
	localparam logic [7:0]  TIMEOUT_RST = 8'd250;

	// one input transfer
	typedef struct packed {
		logic [2:0] func;
		logic [7:0] tx_byte;
		logic       send_ack;
		logic       sda_in;
	} cmd_item_t;

	// one result transfer
	typedef struct packed {
		logic       scl_out;
		logic       sda_out;
		logic       sda_listen;
		logic       busy_res;
		logic       done_res;
		logic [7:0] rx_byte;
		logic       ack_failed;
	} res_item_t;

	// timing settings handed from the register block to the sequencer
	typedef struct packed {
		logic [15:0] short_wait;
		logic [15:0] long_wait;
		logic [7:0]  ack_timeout;
	} cfg_t;

endpackage

/* rtl/i2cm_cfg.sv */
module i2cm_cfg
	import i2cm_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	output cfg_t        cfg
);

	cfg_t       cfg_q;
	logic       wr_en;
	logic [1:0] reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite;
	assign reg_idx = paddr[3:2];
	assign cfg     = cfg_q;

	// register writes, unknown indexes dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.short_wait  <= SHORT_RST;
			cfg_q.long_wait   <= LONG_RST;
			cfg_q.ack_timeout <= TIMEOUT_RST;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_SHORT:   cfg_q.short_wait  <= pwdata[15:0];
				REG_LONG:    cfg_q.long_wait   <= pwdata[15:0];
				REG_TIMEOUT: cfg_q.ack_timeout <= pwdata[7:0];
				default: begin
				end
			endcase
		end
	end

	// read back
	always_comb begin
		unique case (reg_idx)
			REG_SHORT:   prdata = {16'd0, cfg_q.short_wait};
			REG_LONG:    prdata = {16'd0, cfg_q.long_wait};
			REG_TIMEOUT: prdata = {24'd0, cfg_q.ack_timeout};
			default:     prdata = 32'd0;
		endcase
	end

endmodule

/* rtl/i2cm_core.sv */
module i2cm_core
	import i2cm_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      step_en,
	input  cmd_item_t item,
	input  cfg_t      cfg,
	output res_item_t res
);

	typedef enum logic [20:0] {
		PH_IDLE = 21'h000001,
		PH_S0   = 21'h000002,
		PH_S1   = 21'h000004,
		PH_S2   = 21'h000008,
		PH_T0   = 21'h000010,
		PH_T1   = 21'h000020,
		PH_T2   = 21'h000040,
		PH_W0   = 21'h000080,
		PH_W1   = 21'h000100,
		PH_W2   = 21'h000200,
		PH_WP   = 21'h000400,
		PH_B0   = 21'h000800,
		PH_B1   = 21'h001000,
		PH_B2   = 21'h002000,
		PH_B3   = 21'h004000,
		PH_R0   = 21'h008000,
		PH_R1   = 21'h010000,
		PH_R2   = 21'h020000,
		PH_K0   = 21'h040000,
		PH_K1   = 21'h080000,
		PH_K2   = 21'h100000
	} phase_t;

	typedef struct packed {
		phase_t      phase;
		logic [15:0] wait_cnt;
		logic [3:0]  bit_idx;
		logic [7:0]  shift;
		logic [7:0]  poll_cnt;
		logic        scl;
		logic        sda;
		logic        sda_dir_in;
		logic        ack_choice;
		logic        fail;
		logic [7:0]  rx_held;
		logic        done;
		logic        halt;
	} eng_st_t;

	eng_st_t st_q;
	eng_st_t st_pre;
	eng_st_t st_a;
	eng_st_t st_b;
	eng_st_t st_nxt;

	// a zero delay counts as one tick
	function automatic logic [15:0] hold_ticks(input logic [15:0] n);
		return (n == 16'd0) ? 16'd1 : n;
	endfunction

	// one action of the sequencer; does nothing once a wait or poll took the tick
	function automatic eng_st_t run_step(input eng_st_t s, input cfg_t c, input logic sda_i);
		eng_st_t n;
		logic [3:0] bi;
		n  = s;
		bi = s.bit_idx + 4'd1;
		if (s.phase != PH_IDLE && s.wait_cnt == 16'd0 && !s.halt) begin
			unique case (s.phase)
				PH_S0: begin
					n.sda_dir_in = 1'b0; n.sda = 1'b1; n.scl = 1'b1;
					n.phase = PH_S1; n.wait_cnt = hold_ticks(c.long_wait);
				end
				PH_S1: begin
					n.sda = 1'b0;
					n.phase = PH_S2; n.wait_cnt = hold_ticks(c.long_wait);
				end
				PH_S2: begin
					n.scl = 1'b0;
					n.phase = PH_IDLE; n.wait_cnt = 16'd0; n.done = 1'b1;
				end
				PH_T0: begin
					n.sda_dir_in = 1'b0; n.scl = 1'b0; n.sda = 1'b0;
					n.phase = PH_T1; n.wait_cnt = hold_ticks(c.long_wait);
				end
				PH_T1: begin
					n.scl = 1'b1; n.sda = 1'b1;
					n.phase = PH_T2; n.wait_cnt = hold_ticks(c.long_wait);
				end
				PH_T2: begin
					n.phase = PH_IDLE; n.wait_cnt = 16'd0; n.done = 1'b1;
				end
				PH_W0: begin
					n.sda_dir_in = 1'b1; n.sda = 1'b1; n.poll_cnt = 8'd0; n.fail = 1'b0;
					n.phase = PH_W1; n.wait_cnt = hold_ticks(c.short_wait);
				end
				PH_W1: begin
					n.scl = 1'b1;
					n.phase = PH_W2; n.wait_cnt = hold_ticks(c.short_wait);
				end
				PH_W2: n.phase = PH_WP;
				PH_WP: begin
					if (!sda_i) begin
						n.scl = 1'b0;
						n.phase = PH_IDLE; n.wait_cnt = 16'd0; n.done = 1'b1;
					end else if (s.poll_cnt >= c.ack_timeout) begin
						n.fail  = 1'b1;
						n.phase = PH_T0;
					end else begin
						n.poll_cnt = s.poll_cnt + 8'd1;
						n.halt     = 1'b1;
					end
				end
				PH_B0: begin
					n.sda_dir_in = 1'b0; n.scl = 1'b0; n.bit_idx = 4'd0;
					n.phase = PH_B1;
				end
				PH_B1: begin
					n.sda   = s.shift[7];
					n.shift = {s.shift[6:0], 1'b0};
					n.phase = PH_B2; n.wait_cnt = hold_ticks(c.short_wait);
				end
				PH_B2: begin
					n.scl = 1'b1;
					n.phase = PH_B3; n.wait_cnt = hold_ticks(c.short_wait);
				end
				PH_B3: begin
					if (s.scl) begin
						n.scl = 1'b0;
						n.wait_cnt = hold_ticks(c.short_wait);
					end else begin
						n.bit_idx = bi;
						if (bi[3]) begin
							n.phase = PH_IDLE; n.wait_cnt = 16'd0; n.done = 1'b1;
						end else begin
							n.phase = PH_B1;
						end
					end
				end
				PH_R0: begin
					n.scl = 1'b0;
					n.phase = PH_R1; n.wait_cnt = hold_ticks(c.short_wait);
				end
				PH_R1: begin
					n.scl   = 1'b1;
					n.shift = {s.shift[6:0], sda_i};
					n.phase = PH_R2; n.wait_cnt = hold_ticks(c.short_wait);
				end
				PH_R2: begin
					n.bit_idx = bi;
					if (!bi[3]) begin
						n.phase = PH_R0;
					end else begin
						n.rx_held = s.shift;
						n.phase   = PH_K0;
					end
				end
				PH_K0: begin
					n.scl = 1'b0; n.sda_dir_in = 1'b0; n.sda = ~s.ack_choice;
					n.phase = PH_K1; n.wait_cnt = hold_ticks(c.short_wait);
				end
				PH_K1: begin
					n.scl = 1'b1;
					n.phase = PH_K2; n.wait_cnt = hold_ticks(c.short_wait);
				end
				PH_K2: begin
					n.scl = 1'b0;
					n.phase = PH_IDLE; n.wait_cnt = 16'd0; n.done = 1'b1;
				end
				default: begin
					n.phase = PH_IDLE; n.wait_cnt = 16'd0; n.done = 1'b1;
				end
			endcase
		end
		return n;
	endfunction

	// tick entry: count down the wait, or take a command while idle
	always_comb begin
		st_pre      = st_q;
		st_pre.done = 1'b0;
		st_pre.halt = 1'b0;
		if (st_q.wait_cnt != 16'd0) begin
			st_pre.wait_cnt = st_q.wait_cnt - 16'd1;
		end
		if (st_q.phase == PH_IDLE) begin
			st_pre.wait_cnt = 16'd0;
			unique case (item.func)
				FN_START: st_pre.phase = PH_S0;
				FN_STOP:  st_pre.phase = PH_T0;
				FN_WRITE: begin
					st_pre.shift = item.tx_byte;
					st_pre.phase = PH_B0;
				end
				FN_WACK:  st_pre.phase = PH_W0;
				FN_READ: begin
					st_pre.sda_dir_in = 1'b1;
					st_pre.bit_idx    = 4'd0;
					st_pre.shift      = 8'd0;
					st_pre.ack_choice = item.send_ack;
					st_pre.phase      = PH_R0;
				end
				FN_ACK: begin
					st_pre.ack_choice = 1'b1;
					st_pre.phase      = PH_K0;
				end
				FN_NACK: begin
					st_pre.ack_choice = 1'b0;
					st_pre.phase      = PH_K0;
				end
				default: begin
				end
			endcase
		end
	end

	// at most three chained actions happen within one tick
	assign st_a   = run_step(st_pre, cfg, item.sda_in);
	assign st_b   = run_step(st_a, cfg, item.sda_in);
	assign st_nxt = run_step(st_b, cfg, item.sda_in);

	// sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q.phase      <= PH_IDLE;
			st_q.wait_cnt   <= 16'd0;
			st_q.bit_idx    <= 4'd0;
			st_q.shift      <= 8'd0;
			st_q.poll_cnt   <= 8'd0;
			st_q.scl        <= 1'b1;
			st_q.sda        <= 1'b1;
			st_q.sda_dir_in <= 1'b0;
			st_q.ack_choice <= 1'b0;
			st_q.fail       <= 1'b0;
			st_q.rx_held    <= 8'd0;
			st_q.done       <= 1'b0;
			st_q.halt       <= 1'b0;
		end else if (step_en) begin
			st_q <= st_nxt;
		end
	end

	// result of this tick
	always_comb begin
		res.scl_out    = st_nxt.scl;
		res.sda_out    = st_nxt.sda;
		res.sda_listen = st_nxt.sda_dir_in;
		res.busy_res   = (st_nxt.phase != PH_IDLE);
		res.done_res   = st_nxt.done;
		res.rx_byte    = st_nxt.rx_held;
		res.ack_failed = st_nxt.fail;
	end

endmodule

/* rtl/i2c_master_bit_engine.sv */
// I2C master sequencer stepped by one tick per input transfer.
// Input channel (in_valid/in_ready/in_data): each transfer is one tick and
// carries a command code, the byte to write, the ack choice for a read and
// the sampled SDA level. Commands are taken only while idle and ignored
// while a command runs.
// Output channel (out_valid/out_ready/out_data): exactly one result per
// input transfer, with the SCL and SDA drive, SDA direction, busy and done
// flags, the last received byte and the ack failure flag.
// Each input transfer is held in the input register and its result is loaded
// into the result register. Throughput: one transfer per cycle while the
// receiver keeps up, set by the input register feeding a combinational update.
// The input register and result register together let a new transfer be
// taken while a finished result waits; a stalled receiver holds the result
// and the input register, and in_ready drops once both are full.
// Configuration over the APB port: short wait, long wait, ack timeout; write
// only while idle. Reset returns the registers to 100, 200 and 250 ticks,
// the bus lines released and the sequencer idle.
module i2c_master_bit_engine
	import i2cm_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  cmd_item_t   in_data,
	output logic        out_valid,
	input  logic        out_ready,
	output res_item_t   out_data,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	cmd_item_t item_s1;
	logic      valid_s1;
	res_item_t res_q;
	logic      out_valid_q;
	res_item_t res_nxt;
	cfg_t      cfg;
	logic      advance;

	assign advance   = valid_s1 & (~out_valid_q | out_ready);
	assign in_ready  = ~valid_s1 | advance;
	assign out_valid = out_valid_q;
	assign out_data  = res_q;

	// configuration registers
	i2cm_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// bus sequencer
	i2cm_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.step_en (advance),
		.item    (item_s1),
		.cfg     (cfg),
		.res     (res_nxt)
	);

	// input stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid & in_ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// input stage payload
	always_ff @(posedge clk) begin
		if (in_valid & in_ready) begin
			item_s1 <= in_data;
		end
	end

	// result register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// result register payload
	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_nxt;
		end
	end

endmodule
